[src/m4v_pkg.sv]
// shared types and constants for the matrix4 vector transform block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package m4v_pkg;

  localparam int FIELD_W  = 32;
  localparam int IDX_W    = 4;
  localparam int NUM_IN   = 4;
  localparam int NUM_OUT  = 4;
  localparam int PROD_W   = 2 * FIELD_W;
  localparam int S_DATA_W = ((IDX_W + FIELD_W * (NUM_IN + 1) + 7) / 8) * 8;
  localparam int M_DATA_W = ((FIELD_W * NUM_OUT + 7) / 8) * 8;

  localparam logic [FIELD_W-1:0] SAT_MAX = {1'b0, {(FIELD_W - 1){1'b1}}};
  localparam logic [FIELD_W-1:0] SAT_MIN = {1'b1, {(FIELD_W - 1){1'b0}}};

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  // one input word as it travels down the row of cells
  typedef struct packed {
    op_t                             op;
    logic [IDX_W-1:0]                elem_index;
    logic [FIELD_W-1:0]              elem_value;
    logic [NUM_IN-1:0][FIELD_W-1:0]  vec;
  } word_t;

endpackage

[src/m4v_cell.sv]
// one column cell: holds matrix column COL, multiplies it by one vector
// component and adds the products into the running row sums; uses m4v_pkg
`timescale 1ns / 1ps

module m4v_cell
  import m4v_pkg::*;
#(
  parameter int DIM = 4,
  parameter int COL = 0
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  word_t                                             in_word,
  input  logic [DIM-1:0][PROD_W+$clog2(DIM)-1:0]            in_acc,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output word_t                                             out_word,
  output logic [DIM-1:0][PROD_W+$clog2(DIM)-1:0]            out_acc
);

  localparam int ACC_W = PROD_W + $clog2(DIM);

  logic signed [FIELD_W-1:0] col [DIM];

  logic                     s1_valid;
  logic                     s1_ready;
  word_t                    s1_word;
  logic [DIM-1:0][ACC_W-1:0] s1_acc;

  logic                     s2_valid;
  logic                     s2_ready;
  word_t                    s2_word;
  logic [DIM-1:0][ACC_W-1:0] s2_acc;
  logic signed [PROD_W-1:0] s2_prod [DIM];

  logic signed [FIELD_W-1:0] vcomp;
  logic signed [PROD_W-1:0]  prod [DIM];

  // components past the fourth are zero
  generate
    if (COL < NUM_IN) begin : g_comp
      assign vcomp = $signed(s1_word.vec[COL]);
    end else begin : g_zero
      assign vcomp = '0;
    end
  endgenerate

  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      prod[r] = PROD_W'(col[r]) * PROD_W'(vcomp);
    end
  end

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      out_acc[r] = ACC_W'($signed(s2_acc[r]) + ACC_W'(s2_prod[r]));
    end
  end

  assign out_valid = s2_valid;
  assign out_word  = s2_word;

  // a write updates the column as it leaves the first stage, so later
  // words see it and earlier ones have already passed
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      for (int r = 0; r < DIM; r++) begin
        col[r] <= '0;
      end
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s1_valid && s2_ready && s1_word.op == OP_WRITE) begin
        for (int r = 0; r < DIM; r++) begin
          if (int'(s1_word.elem_index) == r * DIM + COL) begin
            col[r] <= $signed(s1_word.elem_value);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_word <= in_word;
      s1_acc  <= in_acc;
    end
    if (s1_valid && s2_ready) begin
      s2_word <= s1_word;
      s2_acc  <= s1_acc;
      for (int r = 0; r < DIM; r++) begin
        s2_prod[r] <= prod[r];
      end
    end
  end

endmodule

[src/m4v_out.sv]
// output stage: shifts out the fraction, saturates each row sum to 32 bits
// and holds the result word; write words are dropped here; uses m4v_pkg
`timescale 1ns / 1ps

module m4v_out
  import m4v_pkg::*;
#(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  op_t                                    in_op,
  input  logic [DIM-1:0][PROD_W+$clog2(DIM)-1:0] in_acc,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [NUM_OUT-1:0][FIELD_W-1:0]        out_res
);

  localparam int ACC_W = PROD_W + $clog2(DIM);
  localparam int TOP_W = ACC_W - FRAC_BITS - FIELD_W + 1;

  logic [NUM_OUT-1:0][FIELD_W-1:0] res_next;

  function automatic logic [FIELD_W-1:0] saturate(input logic [ACC_W-1:0] a);
    logic [TOP_W-1:0] upper;
    upper = a[ACC_W-1:FRAC_BITS+FIELD_W-1];
    if (&upper || ~|upper) begin
      return a[FRAC_BITS+FIELD_W-1:FRAC_BITS];
    end
    return a[ACC_W-1] ? SAT_MIN : SAT_MAX;
  endfunction

  // rows past the matrix size read zero, rows past the fourth are not shown
  generate
    for (genvar r = 0; r < NUM_OUT; r++) begin : g_row
      if (r < DIM) begin : g_live
        assign res_next[r] = saturate(in_acc[r]);
      end else begin : g_none
        assign res_next[r] = '0;
      end
    end
  endgenerate

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid && in_op == OP_XFORM;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_res <= res_next;
    end
  end

endmodule

[src/matrix4_vector_transform_top.sv]
// matrix4 vector transform, top level: unpacks the stream, runs a row of
// column cells and the saturating output stage; uses m4v_pkg, m4v_cell, m4v_out
//
//   channel  dir  handshake                    payload
//   s_axis   in   s_axis_tvalid/s_axis_tready  tuser op, tdata element and vector
//   m_axis   out  m_axis_tvalid/m_axis_tready  tdata out_x..out_w
//
// one word per cycle sustained while the output accepts; a word passes
// two register stages in each column cell (multiply, accumulate) and the
// output register. reset empties the cells and zeroes the matrix.
// a stalled output holds only the stages behind it that are full; bubbles
// close up and input keeps flowing while there is room in the row.
`timescale 1ns / 1ps

module matrix4_vector_transform_top
  import m4v_pkg::*;
#(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // elem_index, elem_value, vec_x, vec_y, vec_z, vec_w, zero pad
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // op
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_x, out_y, out_z, out_w
  output logic [M_DATA_W-1:0] m_axis_tdata
);

  localparam int ACC_W = PROD_W + $clog2(DIM);

  logic                      link_valid [DIM+1];
  logic                      link_ready [DIM+1];
  word_t                     link_word  [DIM+1];
  logic [DIM-1:0][ACC_W-1:0] link_acc   [DIM+1];

  logic [NUM_OUT-1:0][FIELD_W-1:0] res;

  assign link_valid[0]            = s_axis_tvalid;
  assign s_axis_tready            = link_ready[0];
  assign link_word[0].op          = op_t'(s_axis_tuser);
  assign link_word[0].elem_index  = s_axis_tdata[IDX_W-1:0];
  assign link_word[0].elem_value  = s_axis_tdata[IDX_W +: FIELD_W];
  assign link_acc[0]              = '0;

  generate
    for (genvar i = 0; i < NUM_IN; i++) begin : g_vec
      assign link_word[0].vec[i] = s_axis_tdata[IDX_W + FIELD_W * (i + 1) +: FIELD_W];
    end

    for (genvar c = 0; c < DIM; c++) begin : g_cell
      m4v_cell #(
        .DIM (DIM),
        .COL (c)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (link_valid[c]),
        .in_ready  (link_ready[c]),
        .in_word   (link_word[c]),
        .in_acc    (link_acc[c]),
        .out_valid (link_valid[c+1]),
        .out_ready (link_ready[c+1]),
        .out_word  (link_word[c+1]),
        .out_acc   (link_acc[c+1])
      );
    end
  endgenerate

  m4v_out #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (link_valid[DIM]),
    .in_ready  (link_ready[DIM]),
    .in_op     (link_word[DIM].op),
    .in_acc    (link_acc[DIM]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = M_DATA_W'(res);

endmodule

[bench/tb_top.sv]
// self-checking bench for matrix4_vector_transform_top: random and directed
// element writes and vector transforms, checked against a fixed-point predictor
// uses m4v_pkg and the block under test
`timescale 1ns / 1ps

import m4v_pkg::*;

class xform_scoreboard;
  logic [FIELD_W-1:0] matrix [16];
  logic [NUM_OUT-1:0][FIELD_W-1:0] expected_q [$];
  string fld_name [NUM_OUT] = '{"out_x", "out_y", "out_z", "out_w"};
  int n_errors;
  int n_writes;
  int n_xforms;
  int n_checked;
  int n_sat;

  function new();
    foreach (matrix[i]) matrix[i] = '0;
    n_errors  = 0;
    n_writes  = 0;
    n_xforms  = 0;
    n_checked = 0;
    n_sat     = 0;
  endfunction

  // row dot vector: exact 66-bit sum, floor shift, clamp to 32 bits
  function logic [FIELD_W-1:0] row_product(int r, logic [NUM_IN-1:0][FIELD_W-1:0] vec);
    logic signed [65:0] acc;
    logic signed [63:0] prod;
    logic signed [49:0] shifted;
    acc = '0;
    for (int c = 0; c < 4; c++) begin
      prod = $signed(matrix[r * 4 + c]) * $signed(vec[c]);
      acc  = acc + prod;
    end
    shifted = acc >>> 16;
    if (shifted > 50'sd2147483647) begin
      n_sat++;
      return SAT_MAX;
    end
    if (shifted < -50'sd2147483648) begin
      n_sat++;
      return SAT_MIN;
    end
    return shifted[FIELD_W-1:0];
  endfunction

  function void note_word(op_t op, logic [IDX_W-1:0] idx, logic [FIELD_W-1:0] val,
                          logic [NUM_IN-1:0][FIELD_W-1:0] vec);
    logic [NUM_OUT-1:0][FIELD_W-1:0] res;
    if (op == OP_WRITE) begin
      matrix[idx] = val;
      n_writes++;
    end else begin
      for (int r = 0; r < NUM_OUT; r++) res[r] = row_product(r, vec);
      expected_q.push_back(res);
      n_xforms++;
    end
  endfunction

  function void check_result(logic [NUM_OUT-1:0][FIELD_W-1:0] got);
    logic [NUM_OUT-1:0][FIELD_W-1:0] want;
    if (expected_q.size() == 0) begin
      $display("%0t: result word with nothing expected, got %h", $time, got);
      n_errors++;
      return;
    end
    want = expected_q.pop_front();
    n_checked++;
    for (int i = 0; i < NUM_OUT; i++) begin
      if (got[i] !== want[i]) begin
        $display("%0t: %s expected %h actual %h", $time, fld_name[i], want[i], got[i]);
        n_errors++;
      end
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;

  localparam int MAT_DIM   = 4;
  localparam int FRAC      = 16;
  localparam int LIMIT     = 250000;
  localparam int N_RANDOM  = 1100;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // elem_index, elem_value, vec_x, vec_y, vec_z, vec_w, zero pad
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  // op
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // out_x, out_y, out_z, out_w
  logic [M_DATA_W-1:0] m_axis_tdata;

  xform_scoreboard sb = new();
  int  cycles   = 0;
  int  hold_cnt = 0;
  bit  no_idle  = 1'b0;

  matrix4_vector_transform_top #(
    .DIM       (MAT_DIM),
    .FRAC_BITS (FRAC)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result check first, then the accepted input, so a same-edge push never
  // gets popped by the result of an older word
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata[FIELD_W*NUM_OUT-1:0]);
        hold_cnt = no_idle ? 0 : $urandom_range(0, 9);
        m_axis_tready <= (hold_cnt == 0);
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= (hold_cnt == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready)
        sb.note_word(op_t'(s_axis_tuser), s_axis_tdata[IDX_W-1:0],
                     s_axis_tdata[IDX_W+FIELD_W-1:IDX_W],
                     s_axis_tdata[IDX_W+FIELD_W*(NUM_IN+1)-1:IDX_W+FIELD_W]);
    end
  end

  function automatic logic [NUM_IN-1:0][FIELD_W-1:0] make_vec(
      logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
    return {w, z, y, x};
  endfunction

  // biased toward the corners of the range and small magnitudes
  function automatic logic [FIELD_W-1:0] rand_fixed();
    logic [FIELD_W-1:0] corners [7];
    corners = '{SAT_MAX, SAT_MIN, 32'h0, 32'hffff_ffff, 32'h0001_0000, 32'hffff_0000,
                32'h1};
    case ($urandom_range(0, 7))
      0:       return corners[$urandom_range(0, 6)];
      1, 2:    return $urandom_range(0, 32'h7ffff) - 32'h40000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(op_t op, logic [IDX_W-1:0] idx, logic [FIELD_W-1:0] val,
                           logic [NUM_IN-1:0][FIELD_W-1:0] vec);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_DATA_W - IDX_W - FIELD_W * (NUM_IN + 1)){1'b0}}, vec, val, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // the unused fields of each kind of word carry random junk
  task automatic write_elem(logic [IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
    send_word(OP_WRITE, idx, val, make_vec($urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic transform(logic [NUM_IN-1:0][FIELD_W-1:0] vec);
    send_word(OP_XFORM, IDX_W'($urandom), $urandom, vec);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero matrix after reset
    transform(make_vec(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN));
    // identity passes the vector through unchanged
    write_elem(0, 32'h0001_0000);
    write_elem(5, 32'h0001_0000);
    write_elem(10, 32'h0001_0000);
    write_elem(15, 32'h0001_0000);
    transform(make_vec(32'h0001_8000, 32'hfffe_0000, SAT_MAX, SAT_MIN));
    // row 0 overflows upward, row 1 downward
    write_elem(1, SAT_MAX);
    write_elem(2, SAT_MAX);
    write_elem(4, SAT_MIN);
    write_elem(6, SAT_MIN);
    transform(make_vec(SAT_MAX, SAT_MAX, SAT_MAX, 32'h0));
    transform(make_vec(SAT_MAX, 32'h0, SAT_MAX, 32'h0));
    // tiny negative product floors to -1
    write_elem(11, 32'hffff_ffff);
    transform(make_vec(32'h0, 32'h0, 32'h0, 32'h1));
    // min times min is far above the top
    write_elem(15, SAT_MIN);
    transform(make_vec(32'h0, 32'h0, 32'h0, SAT_MIN));
    transform(make_vec(32'h0, 32'h0, 32'h0, SAT_MAX));
    // diagonal entries at the minimum, then all-minimum and all-ones vectors
    for (int i = 0; i < 16; i += 5) write_elem(IDX_W'(i), SAT_MIN);
    transform(make_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
    transform(make_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      no_idle = ((n / 120) % 3 == 1);
      if (n == N_RANDOM / 2)
        drain();
      if ($urandom_range(0, 9) < 4)
        write_elem(IDX_W'($urandom), rand_fixed());
      else
        transform(make_vec(rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed()));
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;
    @(posedge clk);

    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * MAT_DIM + 10) @(posedge clk);

    $display("%0d element writes and %0d transforms sent, %0d results checked",
             sb.n_writes, sb.n_xforms, sb.n_checked);
    $display("%0d output fields clamped, %0d field errors", sb.n_sat, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
